FILE: hdl/pecap_pkg.sv
// Package: shared types and constants for the pickup edge capture core.
`default_nettype none
package pecap_pkg;

	localparam int IGN_DEPTH   = 32;
	localparam int SCOPE_DEPTH = 128;

	localparam int IGN_AW   = $clog2(IGN_DEPTH);
	localparam int IGN_CW   = $clog2(IGN_DEPTH + 1);
	localparam int SCOPE_AW = $clog2(SCOPE_DEPTH);
	localparam int SCOPE_CW = $clog2(SCOPE_DEPTH + 1);

	localparam int TS_W          = 32;
	localparam int CNT_W         = 32;
	localparam int IGN_FILL_W    = 6;
	localparam int SCOPE_FILL_W  = 8;
	localparam int SCOPE_ENTRY_W = TS_W + 2;

	localparam logic [TS_W-1:0] MIN_PERIOD_RESET = TS_W'(3000);

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 152;

	typedef enum logic [1:0] {
		OP_CH1_EDGE  = 2'd0,
		OP_CH2_EDGE  = 2'd1,
		OP_POP_IGN   = 2'd2,
		OP_POP_SCOPE = 2'd3
	} op_t;

	typedef struct packed {
		logic en;
		logic push;
		logic pop;
	} fifo_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/pickup_edge_capture_anomaly_core.sv
// Top level: pickup edge capture with anomaly counting and two event queues.
//
// Each input transaction is either a timestamped pickup edge (s_tuser 0 for channel one,
// 1 for channel two) or a pop of the ignition queue (2) or the scope queue (3), and yields
// exactly one output transaction. One transaction is taken every cycle unless m_tready
// stalls the output; each passes an input register, then a result register, with the queue
// memories read in the same step as the latter. Counters and fill levels in the result are
// the values after that transaction. The user must write min_period_us via cfg_we/cfg_wdata
// while the core is idle; the core does not enforce it. It resets to 3000. No memory clearing is needed after reset.
`default_nettype none
module pickup_edge_capture_anomaly_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [pecap_pkg::TS_W-1:0]            cfg_wdata,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// [31:0] timestamp_us, [32] pin_level, [39:33] zero
	input  wire logic [pecap_pkg::IN_TDATA_W-1:0]      s_tdata,
	// [1:0] op
	input  wire logic [1:0]                            s_tuser,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// [0] pop_valid, [32:1] event_time_us, [33] event_channel, [34] event_level,
	// [35] spark_ch1_strobe, [36] spark_ch2_strobe, [68:37] anomaly_count,
	// [100:69] total_count, [132:101] overrun_count, [138:133] ign_fill,
	// [146:139] scope_fill, [151:147] zero
	output logic      [pecap_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import pecap_pkg::*;

	logic [TS_W-1:0] min_period_q;

	logic            valid_s1;
	op_t             op_s1;
	logic [TS_W-1:0] ts_s1;
	logic            lvl_s1;

	logic            valid_s2;
	logic            pop_valid_s2;
	logic            pop_scope_s2;
	logic            strobe1_s2;
	logic            strobe2_s2;

	logic            adv_s2;
	logic            en;

	fifo_ctl_t       ign_ctl;
	fifo_ctl_t       scope_ctl;
	logic            ign_hit;
	logic            scope_hit;
	logic            scope_drop;
	logic [TS_W-1:0]          ign_rd;
	logic [SCOPE_ENTRY_W-1:0] scope_rd;
	logic [IGN_FILL_W-1:0]    ign_fill;
	logic [SCOPE_FILL_W-1:0]  scope_fill;

	logic             ch1_fall;
	logic             ch2_fall;
	logic [CNT_W-1:0] anomaly_cnt;
	logic [CNT_W-1:0] total_cnt;
	logic [CNT_W-1:0] overrun_cnt;

	logic [TS_W-1:0] ev_time;
	logic            ev_ch;
	logic            ev_lvl;

	assign adv_s2   = !valid_s2 || m_tready;
	assign en       = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;
	assign m_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= MIN_PERIOD_RESET;
		end else if (cfg_we) begin
			min_period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= op_t'(s_tuser);
			ts_s1  <= s_tdata[TS_W-1:0];
			lvl_s1 <= s_tdata[TS_W];
		end
		if (en) begin
			pop_valid_s2 <= ign_hit || scope_hit;
			pop_scope_s2 <= scope_hit;
			strobe1_s2   <= ch1_fall;
			strobe2_s2   <= ch2_fall;
		end
	end

	always_comb begin
		ign_ctl.en     = en;
		ign_ctl.push   = ch1_fall;
		ign_ctl.pop    = (op_s1 == OP_POP_IGN);
		scope_ctl.en   = en;
		scope_ctl.push = (op_s1 == OP_CH1_EDGE) || (op_s1 == OP_CH2_EDGE);
		scope_ctl.pop  = (op_s1 == OP_POP_SCOPE);
	end

	pecap_ign_fifo u_ign (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ign_ctl),
		.push_data (ts_s1),
		.pop_hit   (ign_hit),
		.rd_data   (ign_rd),
		.fill      (ign_fill)
	);

	pecap_scope_fifo u_scope (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scope_ctl),
		.push_data ({lvl_s1, (op_s1 == OP_CH2_EDGE), ts_s1}),
		.pop_hit   (scope_hit),
		.drop      (scope_drop),
		.rd_data   (scope_rd),
		.fill      (scope_fill)
	);

	pecap_monitor u_mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.op          (op_s1),
		.ts          (ts_s1),
		.lvl         (lvl_s1),
		.min_period  (min_period_q),
		.scope_drop  (en && scope_drop),
		.ch1_fall    (ch1_fall),
		.ch2_fall    (ch2_fall),
		.anomaly_cnt (anomaly_cnt),
		.total_cnt   (total_cnt),
		.overrun_cnt (overrun_cnt)
	);

	always_comb begin
		ev_time = '0;
		ev_ch   = 1'b0;
		ev_lvl  = 1'b0;
		if (pop_valid_s2) begin
			if (pop_scope_s2) begin
				ev_time = scope_rd[TS_W-1:0];
				ev_ch   = scope_rd[TS_W];
				ev_lvl  = scope_rd[TS_W+1];
			end else begin
				ev_time = ign_rd;
			end
		end
	end

	assign m_tdata = {
		5'b0,
		scope_fill,
		ign_fill,
		overrun_cnt,
		total_cnt,
		anomaly_cnt,
		strobe2_s2,
		strobe1_s2,
		ev_lvl,
		ev_ch,
		ev_time,
		pop_valid_s2
	};

endmodule
`default_nettype wire

FILE: hdl/pecap_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pecap_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/pecap_ign_fifo.sv
// Ignition event queue: pointers, fill count and timestamp storage.
`default_nettype none
module pecap_ign_fifo (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pecap_pkg::fifo_ctl_t            ctl,
	input  wire logic [pecap_pkg::TS_W-1:0]      push_data,
	output logic                                 pop_hit,
	output logic      [pecap_pkg::TS_W-1:0]      rd_data,
	output logic      [pecap_pkg::IGN_FILL_W-1:0] fill
);
	import pecap_pkg::*;

	logic [IGN_AW-1:0] head_q;
	logic [IGN_CW-1:0] count_q;
	logic [IGN_CW:0]   tail_sum;
	logic [IGN_AW-1:0] tail;
	logic [IGN_AW-1:0] head_nxt;
	logic              full;
	logic              do_push;

	assign full     = (count_q == IGN_CW'(IGN_DEPTH));
	assign do_push  = ctl.en && ctl.push && !full;
	assign pop_hit  = ctl.pop && (count_q != '0);
	assign tail_sum = (IGN_CW+1)'(head_q) + (IGN_CW+1)'(count_q);
	assign tail     = (tail_sum >= (IGN_CW+1)'(IGN_DEPTH)) ?
		IGN_AW'(tail_sum - (IGN_CW+1)'(IGN_DEPTH)) : IGN_AW'(tail_sum);
	assign head_nxt = (head_q == IGN_AW'(IGN_DEPTH - 1)) ? '0 : head_q + IGN_AW'(1);
	assign fill     = IGN_FILL_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.en) begin
			if (do_push) begin
				count_q <= count_q + IGN_CW'(1);
			end else if (pop_hit) begin
				head_q  <= head_nxt;
				count_q <= count_q - IGN_CW'(1);
			end
		end
	end

	pecap_ram #(
		.WIDTH(TS_W),
		.DEPTH(IGN_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (tail),
		.wdata (push_data),
		.re    (ctl.en && pop_hit),
		.raddr (head_q),
		.rdata (rd_data)
	);

endmodule
`default_nettype wire

FILE: hdl/pecap_scope_fifo.sv
// Scope event queue: pointers, fill count, drop detect and entry storage.
`default_nettype none
module pecap_scope_fifo (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pecap_pkg::fifo_ctl_t                ctl,
	input  wire logic [pecap_pkg::SCOPE_ENTRY_W-1:0] push_data,
	output logic                                     pop_hit,
	output logic                                     drop,
	output logic      [pecap_pkg::SCOPE_ENTRY_W-1:0] rd_data,
	output logic      [pecap_pkg::SCOPE_FILL_W-1:0]  fill
);
	import pecap_pkg::*;

	logic [SCOPE_AW-1:0] head_q;
	logic [SCOPE_CW-1:0] count_q;
	logic [SCOPE_CW:0]   tail_sum;
	logic [SCOPE_AW-1:0] tail;
	logic [SCOPE_AW-1:0] head_nxt;
	logic                full;
	logic                do_push;

	assign full     = (count_q == SCOPE_CW'(SCOPE_DEPTH));
	assign do_push  = ctl.en && ctl.push && !full;
	assign drop     = ctl.push && full;
	assign pop_hit  = ctl.pop && (count_q != '0);
	assign tail_sum = (SCOPE_CW+1)'(head_q) + (SCOPE_CW+1)'(count_q);
	assign tail     = (tail_sum >= (SCOPE_CW+1)'(SCOPE_DEPTH)) ?
		SCOPE_AW'(tail_sum - (SCOPE_CW+1)'(SCOPE_DEPTH)) : SCOPE_AW'(tail_sum);
	assign head_nxt = (head_q == SCOPE_AW'(SCOPE_DEPTH - 1)) ? '0 : head_q + SCOPE_AW'(1);
	assign fill     = SCOPE_FILL_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.en) begin
			if (do_push) begin
				count_q <= count_q + SCOPE_CW'(1);
			end else if (pop_hit) begin
				head_q  <= head_nxt;
				count_q <= count_q - SCOPE_CW'(1);
			end
		end
	end

	pecap_ram #(
		.WIDTH(SCOPE_ENTRY_W),
		.DEPTH(SCOPE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (tail),
		.wdata (push_data),
		.re    (ctl.en && pop_hit),
		.raddr (head_q),
		.rdata (rd_data)
	);

endmodule
`default_nettype wire

FILE: hdl/pecap_monitor.sv
// Edge monitor: period anchor, anomaly check, strobes and event counters.
`default_nettype none
module pecap_monitor (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire pecap_pkg::op_t               op,
	input  wire logic [pecap_pkg::TS_W-1:0]   ts,
	input  wire logic                         lvl,
	input  wire logic [pecap_pkg::TS_W-1:0]   min_period,
	input  wire logic                         scope_drop,
	output logic                              ch1_fall,
	output logic                              ch2_fall,
	output logic      [pecap_pkg::CNT_W-1:0]  anomaly_cnt,
	output logic      [pecap_pkg::CNT_W-1:0]  total_cnt,
	output logic      [pecap_pkg::CNT_W-1:0]  overrun_cnt
);
	import pecap_pkg::*;

	logic [TS_W-1:0]  anchor_q;
	logic             await_q;
	logic [CNT_W-1:0] anom_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] drops_q;
	logic [TS_W-1:0]  dt;
	logic             early;
	logic             is_edge;

	assign is_edge  = (op == OP_CH1_EDGE) || (op == OP_CH2_EDGE);
	assign ch1_fall = (op == OP_CH1_EDGE) && !lvl;
	assign ch2_fall = (op == OP_CH2_EDGE) && !lvl;
	assign dt       = ts - anchor_q;
	assign early    = (anchor_q != '0) && (dt < min_period);

	assign anomaly_cnt = anom_q;
	assign total_cnt   = total_q;
	assign overrun_cnt = drops_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q <= '0;
			await_q  <= 1'b0;
			anom_q   <= '0;
			total_q  <= '0;
			drops_q  <= '0;
		end else if (en) begin
			if (ch1_fall) begin
				if (early) begin
					anom_q <= anom_q + CNT_W'(1);
				end else begin
					anchor_q <= ts;
				end
				await_q <= 1'b1;
			end
			if (ch2_fall) begin
				if (!await_q) begin
					anom_q <= anom_q + CNT_W'(1);
				end
				await_q <= 1'b0;
			end
			if (is_edge) begin
				total_q <= total_q + CNT_W'(1);
			end
			if (scope_drop) begin
				drops_q <= drops_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire
